[rtl/swaf_pkg.sv]
// swaf_pkg: shared types and constants for the sliding window anagram finder
// used by swaf_ctrl, swaf_hist and sliding_window_anagram_finder_top; no dependencies
package swaf_pkg;

  // alphabet and letter coding
  localparam int ALPHABET = 26;
  localparam int LETTER_W = 5;

  // window store sizing
  localparam int MAX_PATTERN = 1024;
  localparam int PTR_W       = $clog2(MAX_PATTERN);
  localparam int CNT_W       = $clog2(MAX_PATTERN + 1);

  // balance magnitude stays within MAX_PATTERN
  localparam int BAL_W = $clog2(MAX_PATTERN + 1) + 1;

  // text position
  localparam int          POS_W     = 16;
  localparam longint      MAX_TEXT  = 65536;
  localparam longint      POS_LIMIT = 65535;
  localparam logic [POS_W-1:0] POS_CAP =
    POS_W'((MAX_TEXT - 1 > POS_LIMIT) ? POS_LIMIT : MAX_TEXT - 1);

  // input kind codes
  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_PATTERN = 2'd1;
  localparam logic [1:0] KIND_TEXT    = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [LETTER_W-1:0] letter;
  } swaf_in_t;

  typedef struct packed {
    logic             match;
    logic [POS_W-1:0] start_index;
  } swaf_out_t;

  // operation carried from the control stage to the histogram stage
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_EMPTY   = 2'd3
  } swaf_op_t;

  typedef struct packed {
    logic                valid;
    swaf_op_t            op;
    logic [LETTER_W-1:0] letter;
    logic                evict;
    logic                wfull;
    logic [POS_W-1:0]    start;
  } swaf_stage_t;

endpackage

[rtl/swaf_ctrl.sv]
// swaf_ctrl: window pointers, pattern length, text position and window letter store
// depends on swaf_pkg
module swaf_ctrl import swaf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  swaf_in_t            in_data,
  input  logic                s1_go,
  output swaf_stage_t         s1,
  output logic [LETTER_W-1:0] old_letter
);

  logic [CNT_W-1:0]    plen_r, plen_nxt;
  logic [CNT_W-1:0]    wcount_r, wcount_nxt;
  logic [PTR_W-1:0]    wptr_r, wptr_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  swaf_stage_t         s1_r, s1_nxt;
  logic [LETTER_W-1:0] old_letter_r;
  logic [LETTER_W-1:0] win_mem [MAX_PATTERN];

  logic               is_clear, is_pat, is_txt, letter_ok;
  logic               mem_we, mem_re, evict;
  logic [CNT_W-1:0]   new_wcount;
  logic [POS_W:0]     pos_inc;
  logic [POS_W:0]     start_wide;

  always_comb begin
    letter_ok  = in_data.letter < LETTER_W'(ALPHABET);
    is_clear   = in_data.kind == KIND_CLEAR;
    is_pat     = (in_data.kind == KIND_PATTERN) && letter_ok;
    is_txt     = (in_data.kind == KIND_TEXT) && letter_ok;

    plen_nxt   = plen_r;
    wcount_nxt = wcount_r;
    wptr_nxt   = wptr_r;
    tail_nxt   = tail_r;
    pos_nxt    = pos_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    evict      = wcount_r >= plen_r;
    new_wcount = evict ? wcount_r : wcount_r + CNT_W'(1);
    pos_inc    = {1'b0, pos_r} + (POS_W+1)'(1);
    start_wide = (pos_inc >= (POS_W+1)'(new_wcount)) ?
                 pos_inc - (POS_W+1)'(new_wcount) : '0;

    // a held stage item keeps its fields until it moves on
    s1_nxt = s1_r;
    if (!s1_r.valid || s1_go) begin
      s1_nxt.valid = 1'b0;
    end

    if (in_accept) begin
      s1_nxt.letter = in_data.letter;
      s1_nxt.evict  = 1'b0;
      s1_nxt.wfull  = 1'b0;
      s1_nxt.start  = pos_r;
      s1_nxt.op     = OP_CLEAR;
      if (is_clear) begin
        plen_nxt     = '0;
        wcount_nxt   = '0;
        wptr_nxt     = '0;
        tail_nxt     = '0;
        pos_nxt      = '0;
        s1_nxt.valid = 1'b1;
        s1_nxt.op    = OP_CLEAR;
      end else if (is_pat) begin
        if (plen_r < CNT_W'(MAX_PATTERN)) begin
          plen_nxt     = plen_r + CNT_W'(1);
          s1_nxt.valid = 1'b1;
          s1_nxt.op    = OP_PATTERN;
        end
      end else if (is_txt) begin
        s1_nxt.valid = 1'b1;
        if (pos_r < POS_CAP) begin
          pos_nxt = pos_r + POS_W'(1);
        end
        if (plen_r == '0) begin
          s1_nxt.op = OP_EMPTY;
        end else begin
          s1_nxt.op    = OP_TEXT;
          s1_nxt.evict = evict;
          s1_nxt.wfull = new_wcount == plen_r;
          s1_nxt.start = start_wide[POS_W-1:0];
          mem_we       = 1'b1;
          mem_re       = evict;
          wcount_nxt   = new_wcount;
          wptr_nxt     = (wptr_r == PTR_W'(MAX_PATTERN - 1)) ? '0 : wptr_r + PTR_W'(1);
          if (evict) begin
            tail_nxt = (tail_r == PTR_W'(MAX_PATTERN - 1)) ? '0 : tail_r + PTR_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r   <= '0;
      wcount_r <= '0;
      wptr_r   <= '0;
      tail_r   <= '0;
      pos_r    <= '0;
      s1_r     <= '0;
    end else begin
      plen_r   <= plen_nxt;
      wcount_r <= wcount_nxt;
      wptr_r   <= wptr_nxt;
      tail_r   <= tail_nxt;
      pos_r    <= pos_nxt;
      s1_r     <= s1_nxt;
    end
  end

  // window store: write at the head, read-first at the tail
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wptr_r] <= in_data.letter;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      old_letter_r <= win_mem[tail_r];
    end
  end

  assign s1         = s1_r;
  assign old_letter = old_letter_r;

  a_wcount_le_plen: assert property (@(posedge clk) disable iff (!rst_n)
    wcount_r <= plen_r)
    else $error("window count exceeds pattern length");

  a_plen_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= CNT_W'(MAX_PATTERN))
    else $error("pattern length exceeds maximum");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_r.valid && s1_r.evict) |-> (s1_r.op == OP_TEXT) && s1_r.wfull)
    else $error("eviction without a full text window");

endmodule

[rtl/swaf_hist.sv]
// swaf_hist: per-letter balance lanes, match detection and result register
// depends on swaf_pkg
module swaf_hist import swaf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  swaf_stage_t         s1,
  input  logic                s1_go,
  input  logic [LETTER_W-1:0] old_letter,
  input  logic                out_stall,
  output logic                out_valid,
  output swaf_out_t           out_data
);

  logic signed [BAL_W-1:0] bal_r   [ALPHABET];
  logic signed [BAL_W-1:0] bal_nxt [ALPHABET];
  logic [ALPHABET-1:0]     nxt_zero, cur_zero;
  logic                    inc, dec, hit, has_result;
  logic                    out_valid_r;
  swaf_out_t               out_data_r;

  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      inc = ((s1.op == OP_PATTERN) && (s1.letter == LETTER_W'(i))) ||
            ((s1.op == OP_TEXT) && s1.evict && (old_letter == LETTER_W'(i)));
      dec = (s1.op == OP_TEXT) && (s1.letter == LETTER_W'(i));
      if (s1.op == OP_CLEAR) begin
        bal_nxt[i] = '0;
      end else if (inc && !dec) begin
        bal_nxt[i] = bal_r[i] + BAL_W'(1);
      end else if (dec && !inc) begin
        bal_nxt[i] = bal_r[i] - BAL_W'(1);
      end else begin
        bal_nxt[i] = bal_r[i];
      end
      nxt_zero[i] = bal_nxt[i] == '0;
      cur_zero[i] = bal_r[i] == '0;
    end
    hit        = (s1.op == OP_TEXT) && s1.wfull && (&nxt_zero);
    has_result = (s1.op == OP_TEXT) || (s1.op == OP_EMPTY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET; i++) begin
        bal_r[i] <= '0;
      end
    end else if (s1_go) begin
      for (int i = 0; i < ALPHABET; i++) begin
        bal_r[i] <= bal_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_result) begin
      out_data_r.match       <= hit;
      out_data_r.start_index <= s1.start;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1.op == OP_CLEAR) |=> (&cur_zero))
    else $error("balances not cleared");

  a_rose_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && has_result))
    else $error("result appeared without a stage transfer");

  a_empty_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1.op == OP_EMPTY) |=> out_valid_r && !out_data_r.match)
    else $error("match reported with empty pattern");

endmodule

[rtl/sliding_window_anagram_finder_top.sv]
// sliding_window_anagram_finder_top: top level of the sliding window anagram finder
// depends on swaf_pkg, swaf_ctrl and swaf_hist
//
//   channel  | ports                          | payload
//   ---------+--------------------------------+--------------------------
//   input    | in_valid, in_stall, in_data    | swaf_in_t  (kind, letter)
//   result   | out_valid, out_stall, out_data | swaf_out_t (match, start_index)
//
// one item per cycle sustained unless the result is stalled; a text letter's result
// passes the control stage register, then the balance lanes into the result register
// the window store read for the evicted letter is the one registered memory port
// reset (rst_n low, synchronous) clears counters, balances and valid bits at once;
// the window store is not cleared, entries are read only after being written
// a stalled result holds; the control stage still takes one more item behind it
module sliding_window_anagram_finder_top import swaf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  swaf_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output swaf_out_t out_data
);

  swaf_stage_t         s1;
  logic [LETTER_W-1:0] old_letter;
  logic                s1_go;
  logic                s1_result;
  logic                in_accept;

  // the control stage drains unless its item needs the result register and that is held
  assign s1_result = (s1.op == OP_TEXT) || (s1.op == OP_EMPTY);
  assign s1_go     = s1.valid && (!s1_result || !out_valid || !out_stall);

  // input transfer whenever the control stage is empty or moving on
  assign in_stall  = s1.valid && !s1_go;
  assign in_accept = in_valid && !in_stall;

  // pointers, counters and window store; reads the evicted letter
  swaf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_data    (in_data),
    .s1_go      (s1_go),
    .s1         (s1),
    .old_letter (old_letter)
  );

  // letter balances, match check and the result register
  swaf_hist u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1         (s1),
    .s1_go      (s1_go),
    .old_letter (old_letter),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule
